// ===== rtl/obf_pkg.sv =====
// Shared types and constants for the occupancy bitmap allocator.
// Used by obf_ctrl, obf_dp and occupancy_bitmap_first_free; no dependencies.
`default_nettype none

package obf_pkg;

    localparam int OP_W       = 2;
    localparam int IDX_W      = 10;
    localparam int CAP_W      = 11;
    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 16;

    localparam int DEF_MAX_BITS  = 1024;
    localparam int DEF_WORD_BITS = 64;

    localparam logic [CAP_W-1:0] CAP_RESET = 11'd1024;

    typedef enum logic [OP_W-1:0] {
        OP_MARK_USED = 2'd0,
        OP_MARK_FREE = 2'd1,
        OP_TEST      = 2'd2,
        OP_FIND      = 2'd3
    } t_op;

    // controller -> datapath
    typedef struct packed {
        logic load;   // capture request beat
        logic div;    // compute the word index of the start index
        logic rd;     // first word read, word base and bit offset
        logic modify; // read-modify-write or test
        logic scan;   // one word of the find scan
        logic emit;   // move result into the output register
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic is_find;
        logic scan_done;
        logic out_space;
    } t_stat;

endpackage

`default_nettype wire

// ===== rtl/occupancy_bitmap_first_free.sv =====
// Occupancy bitmap with first-free search: top level.
// Joins obf_ctrl and obf_dp; uses obf_pkg for widths and structs.
//
// Requests arrive on the s_axis channel, one beat per request (op, index);
// every request gives exactly one result beat on m_axis (used, found,
// free_index). Capacity is written through i_cfg_we / i_cfg_wdata; the user
// must do so only while the block is idle, which the block itself does not
// enforce. Writes take effect at the next accepted request. Mark and test
// step through accept, index split, word read, modify or test and output
// load. Find steps through accept, index split and word read, then scans one
// bitmap word per cycle, 1 to MAX_BITS/WORD_BITS words (16 at the defaults),
// through the single read port of the bitmap memory, then loads the output.
// The result is held in an output register; while the receiver stalls
// the next request is accepted and processed, and only its result load
// waits for the output register to drain.
// Reset clears the capacity to 1024 and marks every block free at once
// through per-word valid bits; no clearing pass is needed.
`default_nettype none

module occupancy_bitmap_first_free
    import obf_pkg::*;
#(
    parameter int MAX_BITS  = DEF_MAX_BITS,
    parameter int WORD_BITS = DEF_WORD_BITS
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   s_axis_tvalid,
    output logic                  s_axis_tready,
    input  wire [IN_DATA_W-1:0]   s_axis_tdata,   // [1:0] op, [11:2] index
    output logic                  m_axis_tvalid,
    input  wire                   m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,   // [0] used, [1] found, [11:2] free_index
    input  wire                   i_cfg_we,
    input  wire [CAP_W-1:0]       i_cfg_wdata
);

    t_cmd             cmd;
    t_stat            stat;
    logic             used;
    logic             found;
    logic [IDX_W-1:0] free_index;

    obf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_tvalid (s_axis_tvalid),
        .o_in_tready (s_axis_tready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    obf_dp #(
        .MAX_BITS  (MAX_BITS),
        .WORD_BITS (WORD_BITS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .i_in_op      (s_axis_tdata[OP_W-1:0]),
        .i_in_index   (s_axis_tdata[OP_W+IDX_W-1:OP_W]),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_out_tready (m_axis_tready),
        .o_out_tvalid (m_axis_tvalid),
        .o_used       (used),
        .o_found      (found),
        .o_free_index (free_index)
    );

    assign m_axis_tdata = {{(OUT_DATA_W-IDX_W-2){1'b0}}, free_index, found, used};

endmodule

`default_nettype wire

// ===== rtl/obf_ctrl.sv =====
// Sequencer for the occupancy bitmap allocator.
// Depends on obf_pkg for the command and status structs.
`default_nettype none

module obf_ctrl
    import obf_pkg::*;
(
    input  wire   i_clk,
    input  wire   i_rst_n,
    input  wire   i_in_tvalid,
    output logic  o_in_tready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_DIV    = 6'b000010,
        S_RD     = 6'b000100,
        S_MODIFY = 6'b001000,
        S_SCAN   = 6'b010000,
        S_EMIT   = 6'b100000
    } t_state;

    t_state r_state, n_state;

    assign o_in_tready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_tvalid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.div = 1'b1;
                n_state   = S_RD;
            end
            S_RD: begin
                o_cmd.rd = 1'b1;
                n_state  = i_stat.is_find ? S_SCAN : S_MODIFY;
            end
            S_MODIFY: begin
                o_cmd.modify = 1'b1;
                n_state      = S_EMIT;
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_stat.scan_done) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                // hold until the output register can take the beat
                if (i_stat.out_space) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/obf_dp.sv =====
// Datapath of the occupancy bitmap allocator: capacity register, bitmap
// memory with per-word valid bits, find scan and output register. Uses obf_pkg.
`default_nettype none

module obf_dp
    import obf_pkg::*;
#(
    parameter int MAX_BITS  = DEF_MAX_BITS,
    parameter int WORD_BITS = DEF_WORD_BITS
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  t_cmd              i_cmd,
    output t_stat             o_stat,
    input  wire [OP_W-1:0]    i_in_op,
    input  wire [IDX_W-1:0]   i_in_index,
    input  wire               i_cfg_we,
    input  wire [CAP_W-1:0]   i_cfg_wdata,
    input  wire               i_out_tready,
    output logic              o_out_tvalid,
    output logic              o_used,
    output logic              o_found,
    output logic [IDX_W-1:0]  o_free_index
);

    localparam int NUM_WORDS   = (MAX_BITS + WORD_BITS - 1) / WORD_BITS;
    // only indices below 2**IDX_W can ever be marked
    localparam int IDX_WORDS   = ((1 << IDX_W) + WORD_BITS - 1) / WORD_BITS;
    localparam int STORE_WORDS = (NUM_WORDS < IDX_WORDS) ? NUM_WORDS : IDX_WORDS;
    localparam int MA_W        = (STORE_WORDS > 1) ? $clog2(STORE_WORDS) : 1;
    localparam int OFF_W       = $clog2(WORD_BITS);
    localparam int POS_W       = CAP_W + 1;
    localparam int WC_W        = POS_W - OFF_W + 1;
    localparam int RECIP_SH    = 18;
    localparam int RECIP       = ((1 << RECIP_SH) + WORD_BITS - 1) / WORD_BITS;
    localparam int PROD_W      = IDX_W + RECIP_SH + 1;

    t_op                   r_op;
    logic [IDX_W-1:0]      r_s;
    logic [CAP_W-1:0]      r_cap;
    logic [CAP_W-1:0]      r_effcap;
    logic [WC_W-1:0]       r_q;
    logic [WC_W-1:0]       r_raddr;
    logic [POS_W-1:0]      r_base;
    logic [OFF_W-1:0]      r_off;
    logic                  r_first;
    logic [WORD_BITS-1:0]  r_mem [STORE_WORDS];
    logic [STORE_WORDS-1:0] r_vld;
    logic [WORD_BITS-1:0]  r_rdata;
    logic                  r_rvld;
    logic                  r_res_used;
    logic                  r_res_found;
    logic [IDX_W-1:0]      r_res_idx;
    logic                  r_out_valid;
    logic                  r_out_used;
    logic                  r_out_found;
    logic [IDX_W-1:0]      r_out_idx;

    logic [PROD_W-1:0]     prod;
    logic [POS_W-1:0]      base_q;
    logic [POS_W-1:0]      s_ext;
    logic [WC_W-1:0]       rd_addr;
    logic                  addr_ok;
    logic [WORD_BITS-1:0]  rword;
    logic [WORD_BITS-1:0]  wdata;
    logic [WORD_BITS-1:0]  free_bits;
    logic signed [POS_W:0] lim;
    logic [OFF_W-1:0]      pos;
    logic                  any_free;
    logic [POS_W-1:0]      next_base;
    logic                  last_word;
    logic                  is_mark;
    logic                  in_cap;

    // exact quotient for every start index: ceil reciprocal, wide shift
    assign prod   = PROD_W'(r_s) * PROD_W'(RECIP);
    assign base_q = POS_W'(r_q * WORD_BITS);
    assign s_ext  = POS_W'(r_s);

    assign rd_addr = i_cmd.scan ? r_raddr : r_q;
    assign addr_ok = (32'(rd_addr) < STORE_WORDS);
    assign rword   = r_rvld ? r_rdata : '0;

    assign is_mark = (r_op == OP_MARK_USED) || (r_op == OP_MARK_FREE);
    assign in_cap  = ({1'b0, r_s} < r_effcap);

    always_comb begin
        wdata        = rword;
        wdata[r_off] = (r_op == OP_MARK_USED);
    end

    // lim = capacity - word base: bit j of this word is in range when j < lim
    assign lim = $signed({2'b00, r_effcap}) - $signed({1'b0, r_base});

    always_comb begin
        for (int j = 0; j < WORD_BITS; j++) begin
            free_bits[j] = !rword[j]
                        && ($signed((POS_W+1)'(j)) < lim)
                        && !(r_first && (OFF_W'(j) < r_off));
        end
    end

    always_comb begin
        pos = '0;
        for (int j = WORD_BITS - 1; j >= 0; j--) begin
            if (free_bits[j]) begin
                pos = OFF_W'(j);
            end
        end
    end

    assign any_free  = |free_bits;
    assign next_base = r_base + POS_W'(WORD_BITS);
    assign last_word = ({1'b0, r_effcap} <= next_base);

    assign o_stat.is_find   = (r_op == OP_FIND);
    assign o_stat.scan_done = any_free || last_word;
    assign o_stat.out_space = !r_out_valid || i_out_tready;

    // request, scan and result registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op        <= t_op'(i_in_op);
            r_s         <= i_in_index;
            r_res_used  <= 1'b0;
            r_res_found <= 1'b0;
            r_res_idx   <= '0;
            if (32'(r_cap) > MAX_BITS) begin
                r_effcap <= CAP_W'(MAX_BITS);
            end else begin
                r_effcap <= r_cap;
            end
        end
        if (i_cmd.div) begin
            r_q <= WC_W'(prod >> RECIP_SH);
        end
        if (i_cmd.rd) begin
            r_base  <= base_q;
            r_off   <= OFF_W'(s_ext - base_q);
            r_raddr <= r_q + WC_W'(1);
            r_first <= 1'b1;
        end
        if (i_cmd.modify && (r_op == OP_TEST)) begin
            r_res_used <= !in_cap || rword[r_off];
        end
        if (i_cmd.scan) begin
            r_raddr <= r_raddr + WC_W'(1);
            r_base  <= next_base;
            r_first <= 1'b0;
            if (any_free) begin
                r_res_found <= 1'b1;
                r_res_idx   <= IDX_W'(r_base + POS_W'(pos));
            end
        end
        if (i_cmd.emit) begin
            r_out_used  <= r_res_used;
            r_out_found <= r_res_found;
            r_out_idx   <= r_res_idx;
        end
    end

    // bitmap memory, one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.modify && is_mark && in_cap) begin
            r_mem[r_q[MA_W-1:0]] <= wdata;
        end
        r_rdata <= r_mem[rd_addr[MA_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld       <= '0;
            r_rvld      <= 1'b0;
            r_cap       <= CAP_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_rvld <= addr_ok && r_vld[rd_addr[MA_W-1:0]];
            if (i_cmd.modify && is_mark && in_cap) begin
                r_vld[r_q[MA_W-1:0]] <= 1'b1;
            end
            if (i_cfg_we) begin
                r_cap <= i_cfg_wdata;
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_tvalid = r_out_valid;
    assign o_used       = r_out_used;
    assign o_found      = r_out_found;
    assign o_free_index = r_out_idx;

endmodule

`default_nettype wire

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// Testbench for occupancy_bitmap_first_free: sends mark, test and find requests,
// keeps its own copy of the occupancy map to predict each result beat and checks them in order.
// Depends on obf_pkg and the RTL of the block only.

module tb_top;
    import obf_pkg::*;

    localparam int MAP_BITS        = DEF_MAX_BITS;
    localparam int WATCHDOG_CYCLES = 400000;
    localparam int TAIL_CYCLES     = 40;

    typedef struct packed {
        logic [IDX_W-1:0] free_index;
        logic             found;
        logic             used;
    } t_result;

    logic                  i_clk          = 1'b0;
    logic                  i_rst_n        = 1'b0;
    logic                  s_axis_tvalid  = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata   = '0;    // [1:0] op, [11:2] index
    logic                  m_axis_tvalid;
    logic                  m_axis_tready  = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;           // [0] used, [1] found, [11:2] free_index
    logic                  i_cfg_we       = 1'b0;
    logic [CAP_W-1:0]      i_cfg_wdata    = '0;

    // predicted state of the block
    logic [MAP_BITS-1:0]   occ_bits;
    logic [CAP_W-1:0]      capacity_reg;

    t_result pending_results[$];
    t_result last_prediction;
    t_result seen_result;
    t_result want_result;
    int      mismatch_count = 0;
    int      cycle_count    = 0;
    int      send_idle_pct  = 0;
    int      recv_idle_pct  = 0;
    int      drain_wait;

    occupancy_bitmap_first_free i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    initial begin
        wait (cycle_count >= WATCHDOG_CYCLES);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    always @(negedge i_clk) begin
        m_axis_tready <= i_rst_n && ($urandom_range(99) >= recv_idle_pct);
    end

    function automatic int usable_bits();
        return (capacity_reg > CAP_W'(MAP_BITS)) ? MAP_BITS : int'(capacity_reg);
    endfunction

    // Apply one request to the map copy and return the result beat it should give.
    function automatic t_result predict_bitmap_op(input t_op op, input logic [IDX_W-1:0] idx);
        t_result r;
        int      lim;
        int      b;
        r   = '0;
        lim = usable_bits();
        case (op)
            OP_MARK_USED: begin
                if (int'(idx) < lim) occ_bits[idx] = 1'b1;
            end
            OP_MARK_FREE: begin
                if (int'(idx) < lim) occ_bits[idx] = 1'b0;
            end
            OP_TEST: begin
                r.used = (int'(idx) >= lim) || occ_bits[idx];
            end
            default: begin
                for (b = int'(idx); b < lim && !r.found; b++) begin
                    if (!occ_bits[b]) begin
                        r.found      = 1'b1;
                        r.free_index = b[IDX_W-1:0];
                    end
                end
            end
        endcase
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            seen_result = t_result'(m_axis_tdata[IDX_W+1:0]);
            if (pending_results.size() == 0) begin
                $error("result beat with no request outstanding: tdata=%h", m_axis_tdata);
                mismatch_count++;
            end else begin
                want_result = pending_results.pop_front();
                if (seen_result.used !== want_result.used) begin
                    $error("used: expected %0d, got %0d", want_result.used, seen_result.used);
                    mismatch_count++;
                end
                if (seen_result.found !== want_result.found) begin
                    $error("found: expected %0d, got %0d", want_result.found, seen_result.found);
                    mismatch_count++;
                end
                if (seen_result.free_index !== want_result.free_index) begin
                    $error("free_index: expected %0d, got %0d",
                           want_result.free_index, seen_result.free_index);
                    mismatch_count++;
                end
            end
        end
    end

    // Present one request beat, hold it until accepted, then record its prediction.
    task automatic send_request(input t_op op, input logic [IDX_W-1:0] idx);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(IN_DATA_W-IDX_W-OP_W){1'b0}}, idx, op};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        last_prediction = predict_bitmap_op(op, idx);
        pending_results.push_back(last_prediction);
    endtask

    // Drain all outstanding results first so the write lands while the block is idle.
    task automatic write_capacity(input logic [CAP_W-1:0] value);
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we     <= 1'b0;
        capacity_reg = value;
    endtask

    task automatic test_empty_map_after_reset();
        send_request(OP_FIND, 10'd0);
        send_request(OP_FIND, 10'd1023);
        send_request(OP_TEST, 10'd0);
    endtask

    task automatic test_mark_and_test();
        send_request(OP_MARK_USED, 10'd0);
        send_request(OP_TEST, 10'd0);
        send_request(OP_FIND, 10'd0);
        send_request(OP_MARK_USED, 10'd1023);
        send_request(OP_TEST, 10'd1023);
        send_request(OP_FIND, 10'd1023);        // nothing free at or above the start
        send_request(OP_MARK_FREE, 10'd0);
        send_request(OP_TEST, 10'd0);
        send_request(OP_FIND, 10'd0);
        send_request(OP_MARK_FREE, 10'd1023);
    endtask

    task automatic test_capacity_limits();
        write_capacity(11'd2047);               // saturates at the map size
        send_request(OP_TEST, 10'd1023);
        send_request(OP_FIND, 10'd1020);
        write_capacity(11'd0);
        send_request(OP_MARK_USED, 10'd0);
        send_request(OP_TEST, 10'd0);
        send_request(OP_FIND, 10'd0);
        write_capacity(11'd1);
        send_request(OP_MARK_USED, 10'd0);
        send_request(OP_FIND, 10'd0);
        send_request(OP_TEST, 10'd1);
        write_capacity(11'd1024);
        send_request(OP_MARK_FREE, 10'd0);
    endtask

    task automatic test_capacity_change_keeps_bits();
        send_request(OP_MARK_USED, 10'd50);
        write_capacity(11'd10);
        send_request(OP_TEST, 10'd50);
        send_request(OP_MARK_FREE, 10'd50);     // out of range, must not clear
        write_capacity(11'd1024);
        send_request(OP_TEST, 10'd50);
    endtask

    function automatic logic [CAP_W-1:0] pick_capacity();
        case ($urandom_range(9))
            0:       return 11'd0;
            1:       return 11'd1;
            2:       return 11'd2047;
            3:       return 11'd1024;
            4:       return 11'd64;
            5:       return 11'd65;
            6:       return CAP_W'($urandom_range(200, 2));
            7:       return CAP_W'($urandom_range(2047, 1025));
            default: return CAP_W'($urandom_range(1024, 0));
        endcase
    endfunction

    // Mostly inside capacity, sometimes anywhere in the index range.
    function automatic logic [IDX_W-1:0] pick_index();
        int lim;
        lim = usable_bits();
        if (lim > 0 && $urandom_range(3) != 0) return IDX_W'($urandom_range(lim - 1, 0));
        return IDX_W'($urandom_range(1023, 0));
    endfunction

    // Allocator-like traffic: find then claim dominates, with frees, tests and noise.
    // n_ops counts request beats, the claim after a find included.
    task automatic test_random_traffic(input int send_pct, input int recv_pct, input int n_ops);
        int roll;
        int k;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        for (k = 0; k < n_ops; k++) begin
            if (k % 100 == 0) write_capacity(pick_capacity());
            roll = $urandom_range(99);
            if (roll < 40) begin
                send_request(OP_FIND, ($urandom_range(1) == 0) ? 10'd0 : pick_index());
                if (last_prediction.found) begin
                    send_request(OP_MARK_USED, last_prediction.free_index);
                    k++;
                end
            end else if (roll < 60) begin
                send_request(OP_MARK_FREE, pick_index());
            end else if (roll < 72) begin
                send_request(OP_TEST, pick_index());
            end else if (roll < 82) begin
                send_request(OP_MARK_USED, pick_index());
            end else begin
                send_request(t_op'($urandom_range(3)), IDX_W'($urandom_range(1023, 0)));
            end
        end
    endtask

    initial begin
        occ_bits     = '0;
        capacity_reg = CAP_RESET;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_idle_pct = 36;
        recv_idle_pct = 45;
        test_empty_map_after_reset();
        test_mark_and_test();
        test_capacity_limits();
        test_capacity_change_keeps_bits();
        test_random_traffic(36, 45, 600);
        test_random_traffic(45, 36, 600);
        test_random_traffic(0, 0, 600);

        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        drain_wait = 0;
        while (pending_results.size() != 0 && drain_wait < 5000) begin
            @(posedge i_clk);
            drain_wait++;
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (pending_results.size() != 0) begin
            $error("%0d expected result beats never arrived", pending_results.size());
            mismatch_count++;
        end
        if (mismatch_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
